// ----- hw/rtl/rrf_pkg.sv -----
// Shared types, constants and GF(2) helpers for the rolling Rabin fingerprint.
// No dependencies.
package rrf_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int POLY_W     = 57;
    localparam int FP_W       = 56;
    localparam int WIN_W      = 7;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int DEG_W      = 6;
    localparam int CNT_W      = $clog2(8 * MAX_WINDOW + 1);

    localparam logic [POLY_W-1:0] POLY_RESET = 57'd17349423945073011;
    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0]  WIN_MAX    = WIN_W'(MAX_WINDOW);

    localparam logic REG_POLYNOMIAL  = 1'b0;
    localparam logic REG_WINDOW_SIZE = 1'b1;

    localparam logic ACT_SLIDE   = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic             busy;
        logic [DEG_W-1:0] degree;
        logic [FP_W-1:0]  shift_term;
    } setup_status_t;

    // Multiply v (degree below k) by x and reduce modulo p.
    function automatic logic [FP_W-1:0] times_x(input logic [FP_W-1:0] v,
                                                 input logic [POLY_W-1:0] p,
                                                 input logic [DEG_W-1:0] k);
        logic [POLY_W-1:0] s;
        s = {v, 1'b0};
        if (s[k]) begin
            s = s ^ p;
        end
        return s[FP_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rrf_window_mem.sv -----
// Window byte store: synchronous RAM with per-entry valid bits, registered read.
// Depends on rrf_pkg.
module rrf_window_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear,
    input  logic                      wr_en,
    input  logic [rrf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [rrf_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0]                     mem [rrf_pkg::MAX_WINDOW];
    logic [rrf_pkg::MAX_WINDOW-1:0] valid_reg;
    logic [7:0]                     rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < rrf_pkg::MAX_WINDOW; i++) begin
                if (wr_en && wr_addr == rrf_pkg::ADDR_W'(i)) begin
                    valid_reg[i] <= 1'b1;
                end else if (clear) begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rrf_setup.sv -----
// Setup sequencer: finds the polynomial degree, then builds x^(8w) mod P.
// Depends on rrf_pkg.
module rrf_setup (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rrf_pkg::POLY_W-1:0]  polynomial,
    input  logic [rrf_pkg::WIN_W-1:0]   window_size,
    output rrf_pkg::setup_status_t      status
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_BUILD} state_t;

    state_t                      state_reg;
    logic [rrf_pkg::DEG_W-1:0]   deg_reg;
    logic [rrf_pkg::CNT_W-1:0]   cnt_reg;
    logic [rrf_pkg::FP_W-1:0]    term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
            deg_reg   <= rrf_pkg::DEG_W'(rrf_pkg::FP_W);
        end else if (start) begin
            state_reg <= ST_SCAN;
            deg_reg   <= rrf_pkg::DEG_W'(rrf_pkg::FP_W);
        end else begin
            case (state_reg)
                ST_SCAN: begin
                    // walk down from the top bit until the leading one
                    if (polynomial[deg_reg]) begin
                        state_reg <= ST_BUILD;
                        cnt_reg   <= {window_size, 3'b000};
                        term_reg  <= rrf_pkg::FP_W'(1);
                    end else begin
                        deg_reg <= deg_reg - 1'b1;
                    end
                end
                ST_BUILD: begin
                    term_reg <= rrf_pkg::times_x(term_reg, polynomial, deg_reg);
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == rrf_pkg::CNT_W'(1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.degree     = deg_reg;
    assign status.shift_term = term_reg;

endmodule

// ----- hw/rtl/rolling_rabin_fingerprint.sv -----
// Top level of the rolling Rabin fingerprint: config, item sequencer, datapath.
// Depends on rrf_pkg, rrf_window_mem and rrf_setup.
//
// Usage:
//   Input channel s_*: one request per byte. s_action = 0 slides s_byte_in into
//   the window; s_action = 1 restarts (window cleared, digest becomes 1).
//   Result channel m_*: exactly one m_fingerprint per request, in order.
//   Config port: cfg_wr_en/cfg_index/cfg_data; index 0 is the polynomial
//   (writes below 512 are dropped), index 1 the window size (low 7 bits used;
//   0 taken as 1, above 64 taken as 64). Write only while the block is idle.
// Sequence:
//   A slide request goes through one window RAM read, eight bit steps of the
//   GF(2) multiply-and-reduce unit and one result load. A restart request
//   goes straight to the result load. One request is in flight at a
//   time; the next is accepted while the previous result still waits.
// Reset and config:
//   After reset or a config write the setup unit scans for the polynomial
//   degree and builds x^(8*w) mod P; s_ready stays low meanwhile. A stalled
//   receiver holds the result register; the block then finishes the next
//   request and waits with it.
module rolling_rabin_fingerprint (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [7:0]                 s_byte_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rrf_pkg::FP_W-1:0]   m_fingerprint,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [rrf_pkg::POLY_W-1:0] cfg_data
);

    typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_READ, ST_STEP, ST_DONE} state_t;

    localparam int A = rrf_pkg::ADDR_W;
    localparam int F = rrf_pkg::FP_W;

    state_t                    state_reg;
    logic [rrf_pkg::POLY_W-1:0] poly_reg;
    logic [rrf_pkg::WIN_W-1:0]  win_reg;
    logic [A-1:0]              wp_reg;
    logic [F-1:0]              digest_reg;
    logic [F-1:0]              d_reg, a_reg;
    logic [F-1:0]              d_next, a_next;
    logic [7:0]                byte_reg, old_reg;
    logic [2:0]                bit_reg;
    logic                      m_valid_reg;
    logic [F-1:0]              m_fp_reg;
    logic                      cfg_take;
    logic [rrf_pkg::WIN_W-1:0] win_clamped;
    logic                      accept;
    logic                      restart;
    logic [A-1:0]              wp_first;
    logic [A-1:0]              wp_inc;
    logic                      out_free;

    rrf_pkg::setup_status_t    setup;

    logic       mem_clear, mem_we;
    logic [A-1:0] mem_waddr;
    logic [7:0] mem_wdata, mem_rdata;

    // Config: decode and clamp
    always_comb begin
        win_clamped = cfg_data[rrf_pkg::WIN_W-1:0];
        if (win_clamped == '0) begin
            win_clamped = rrf_pkg::WIN_W'(1);
        end else if (win_clamped > rrf_pkg::WIN_MAX) begin
            win_clamped = rrf_pkg::WIN_MAX;
        end
        case (cfg_index)
            rrf_pkg::REG_POLYNOMIAL:  cfg_take = cfg_wr_en && (cfg_data[56:9] != '0);
            rrf_pkg::REG_WINDOW_SIZE: cfg_take = cfg_wr_en;
            default:                  cfg_take = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= rrf_pkg::POLY_RESET;
            win_reg  <= rrf_pkg::WIN_RESET;
        end else if (cfg_take) begin
            if (cfg_index == rrf_pkg::REG_POLYNOMIAL) begin
                poly_reg <= cfg_data;
            end else begin
                win_reg <= win_clamped;
            end
        end
    end

    rrf_setup u_setup (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cfg_take),
        .polynomial (poly_reg),
        .window_size(win_reg),
        .status     (setup)
    );

    // Handshake and window pointer helpers
    assign s_ready  = (state_reg == ST_IDLE) && !setup.busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign restart  = (state_reg == ST_INIT) || (accept && s_action == rrf_pkg::ACT_RESTART);
    assign wp_first = (win_reg == rrf_pkg::WIN_W'(1)) ? '0 : A'(1);
    assign wp_inc   = (({1'b0, wp_reg} + 1'b1) == win_reg) ? '0 : wp_reg + 1'b1;

    // Restart writes byte 1 into entry 0 over a cleared window;
    // a slide writes the new byte where the oldest one was read
    assign mem_clear = restart;
    assign mem_we    = restart || (state_reg == ST_READ);
    assign mem_waddr = restart ? '0 : wp_reg;
    assign mem_wdata = restart ? 8'd1 : byte_reg;

    rrf_window_mem u_window (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clear  (mem_clear),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_addr(wp_reg),
        .rd_data(mem_rdata)
    );

    // One bit step: digest*x + new bit, and drop term via old*x^(8w)
    always_comb begin
        d_next = rrf_pkg::times_x(d_reg, poly_reg, setup.degree)
                 ^ F'(byte_reg[bit_reg]);
        a_next = rrf_pkg::times_x(a_reg, poly_reg, setup.degree)
                 ^ (old_reg[bit_reg] ? setup.shift_term : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            // a result loaded in ST_DONE takes the place of the one leaving
            if (m_valid_reg && m_ready && (state_reg != ST_DONE || cfg_take)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_take) begin
                // rebuild and restart after any accepted write
                state_reg <= ST_INIT;
            end else begin
                case (state_reg)
                    ST_INIT: begin
                        digest_reg <= F'(1);
                        wp_reg     <= wp_first;
                        state_reg  <= ST_IDLE;
                    end
                    ST_IDLE: begin
                        if (accept) begin
                            byte_reg <= s_byte_in;
                            if (s_action == rrf_pkg::ACT_RESTART) begin
                                digest_reg <= F'(1);
                                wp_reg     <= wp_first;
                                state_reg  <= ST_DONE;
                            end else begin
                                state_reg <= ST_READ;
                            end
                        end
                    end
                    ST_READ: begin
                        // oldest byte arrives; advance the pointer
                        old_reg   <= mem_rdata;
                        wp_reg    <= wp_inc;
                        d_reg     <= digest_reg;
                        a_reg     <= '0;
                        bit_reg   <= 3'd7;
                        state_reg <= ST_STEP;
                    end
                    ST_STEP: begin
                        d_reg   <= d_next;
                        a_reg   <= a_next;
                        bit_reg <= bit_reg - 1'b1;
                        if (bit_reg == 3'd0) begin
                            digest_reg <= d_next ^ a_next;
                            state_reg  <= ST_DONE;
                        end
                    end
                    ST_DONE: begin
                        // hold until the result register is free
                        if (out_free) begin
                            m_valid_reg <= 1'b1;
                            m_fp_reg    <= digest_reg;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fingerprint = m_fp_reg;

endmodule

// ----- hw/rtl/rrf_checker.sv -----
// Port-level checker for rolling_rabin_fingerprint, bound to the top level.
// Depends on rrf_pkg.
module rrf_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_action,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [rrf_pkg::FP_W-1:0] m_fingerprint
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fingerprint))
        else $error("result dropped or changed while stalled");

    // one request in flight at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // restart passes through ST_DONE and shows digest 1 when output is free
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action && !m_valid |=> ##1 m_valid && m_fingerprint == 1)
        else $error("restart digest is not one");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("outputs active after reset");

endmodule

bind rolling_rabin_fingerprint rrf_checker u_rrf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_action     (s_action),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_fingerprint(m_fingerprint)
);
